// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that an expression never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/pscl_pkg.sv =====
// ----------------------------------------------------------------------------
// pscl_pkg
// Types and constants of the per-source connection limiter.
// ----------------------------------------------------------------------------
package pscl_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } t_state;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_RECORDED   = 3'd0,
        STAT_UNTRACKED  = 3'd1,
        STAT_NO_SLOT    = 3'd2,
        STAT_OVER_LIMIT = 3'd3,
        STAT_RELEASED   = 3'd4,
        STAT_NOT_FOUND  = 3'd5
    } t_status;

    // Opcodes
    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_USED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V4_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_V6_LEN     = 3'd4;

    // Field widths
    localparam int ID_W      = 16;
    localparam int HALF_W    = 64;
    localparam int V4_W      = 32;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;
    localparam int V4_LEN_W  = 6;
    localparam int V6_LEN_W  = 8;

    // Register reset values
    localparam logic [6:0]          RST_SLOTS_USED = 7'd64;
    localparam logic [6:0]          RST_SRC_LIMIT  = 7'd64;
    localparam logic [V4_LEN_W-1:0] RST_V4_LEN     = 6'd32;
    localparam logic [V6_LEN_W-1:0] RST_V6_LEN     = 8'd128;

    // Longest usable prefix of each family
    localparam logic [V4_LEN_W-1:0] V4_MAX_LEN = 6'd32;
    localparam logic [V6_LEN_W-1:0] V6_MAX_LEN = 8'd128;

    // One table slot
    typedef struct packed {
        logic              used;
        logic [ID_W-1:0]   conn_id;
        logic              family;
        logic [HALF_W-1:0] pfx_upper;
        logic [HALF_W-1:0] pfx_lower;
    } t_slot;

endpackage

// ===== hw/rtl/per_source_connection_limiter.sv =====
// ----------------------------------------------------------------------------
// per_source_connection_limiter
// Slot table of open connections with a per-source-prefix admission limit,
// scanned one slot per cycle through a one-write, one-read slot memory.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                         Direction
//  command   start, busy, i_opcode, i_conn_id, i_addr_known,  in (busy out)
//            i_is_ipv6, i_addr_upper, i_addr_lower
//  result    o_result_valid, o_allowed, o_status,             out
//            o_slot_index, o_source_count
//  config    i_cfg_we, i_cfg_index, i_cfg_wdata               in
//
//  A command beat is taken when start is high and busy is low.
//  Untracked checks, releases with limiting off and empty scans answer in
//  the cycle after the beat is taken. Other items scan min(slots_in_use,
//  SLOTS) slots in turn, paced by the one read port of the slot memory and
//  the single slot comparator; a release ends early at its first matching
//  slot. After reset a clearing pass walks all SLOTS entries with busy
//  high; configuration writes are taken throughout.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_source_connection_limiter #(
    parameter int SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [pscl_pkg::ID_W-1:0]           i_conn_id,
    input  logic                                i_addr_known,
    input  logic                                i_is_ipv6,
    input  logic [pscl_pkg::HALF_W-1:0]         i_addr_upper,
    input  logic [pscl_pkg::HALF_W-1:0]         i_addr_lower,
    input  logic                                i_cfg_we,
    input  logic [pscl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pscl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                o_result_valid,
    output logic                                o_allowed,
    output logic [2:0]                          o_status,
    output logic [pscl_pkg::IDX_OUT_W-1:0]      o_slot_index,
    output logic [pscl_pkg::CNT_OUT_W-1:0]      o_source_count
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (CW > 7) ? CW : 7;

    // Configuration registers
    logic                              r_limit_en;
    logic [6:0]                        r_slots_used;
    logic [6:0]                        r_src_limit;
    logic [pscl_pkg::V4_LEN_W-1:0]     r_v4_len;
    logic [pscl_pkg::V6_LEN_W-1:0]     r_v6_len;

    // Sequencer and item registers
    pscl_pkg::t_state                  r_state, n_state;
    logic [CW-1:0]                     r_addr, n_addr;
    logic                              r_rd_vld, n_rd_vld;
    logic [AW-1:0]                     r_rd_idx;
    pscl_pkg::t_slot                   r_rd_data;
    logic [CW-1:0]                     r_count, n_count;
    logic                              r_have_free, n_have_free;
    logic [AW-1:0]                     r_free_idx, n_free_idx;
    logic                              r_opcode;
    logic [pscl_pkg::ID_W-1:0]         r_conn_id;
    logic                              r_family;
    logic [pscl_pkg::HALF_W-1:0]       r_pfx_upper;
    logic [pscl_pkg::HALF_W-1:0]       r_pfx_lower;
    logic [CW-1:0]                     r_scan_len;

    // Result registers
    logic                              r_out_valid, n_out_valid;
    logic                              r_allowed, n_allowed;
    pscl_pkg::t_status                 r_status, n_status;
    logic [pscl_pkg::IDX_OUT_W-1:0]    r_slot_index, n_slot_index;
    logic [pscl_pkg::CNT_OUT_W-1:0]    r_source_count, n_source_count;

    // Slot memory
    pscl_pkg::t_slot                   r_slot_mem [SLOTS];
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    pscl_pkg::t_slot                   mem_wdata;

    // Front-end signals
    logic                              accept;
    logic [pscl_pkg::V4_W-1:0]         mask_v4;
    logic [pscl_pkg::HALF_W-1:0]       mask_v6_up;
    logic [pscl_pkg::HALF_W-1:0]       mask_v6_lo;
    logic [pscl_pkg::HALF_W-1:0]       in_pfx_upper;
    logic [pscl_pkg::HALF_W-1:0]       in_pfx_lower;
    logic                              pfx_bad;
    logic                              untracked;
    logic [CW-1:0]                     len_in;

    // Scan compare signals
    logic                              hit_id;
    logic                              hit_src;
    logic                              is_free;
    logic                              last;
    logic [CW-1:0]                     count_nx;
    logic                              have_free_nx;
    logic [AW-1:0]                     free_nx;
    logic [pscl_pkg::CNT_OUT_W-1:0]    count_sat;

    assign accept = start && (r_state == pscl_pkg::S_IDLE);
    assign busy   = (r_state != pscl_pkg::S_IDLE);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en   <= 1'b0;
            r_slots_used <= pscl_pkg::RST_SLOTS_USED;
            r_src_limit  <= pscl_pkg::RST_SRC_LIMIT;
            r_v4_len     <= pscl_pkg::RST_V4_LEN;
            r_v6_len     <= pscl_pkg::RST_V6_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pscl_pkg::CFG_LIMIT_EN:   r_limit_en   <= i_cfg_wdata[0];
                pscl_pkg::CFG_SLOTS_USED: r_slots_used <= i_cfg_wdata[6:0];
                pscl_pkg::CFG_SRC_LIMIT:  r_src_limit  <= i_cfg_wdata[6:0];
                pscl_pkg::CFG_V4_LEN:     r_v4_len     <= i_cfg_wdata[pscl_pkg::V4_LEN_W-1:0];
                pscl_pkg::CFG_V6_LEN:     r_v6_len     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Build prefix masks: keep bit j when it lies in the leading prefix
    always_comb begin
        for (int j = 0; j < pscl_pkg::V4_W; j++) begin
            mask_v4[j] = (9'(j) + 9'(r_v4_len)) >= 9'd32;
        end
        for (int j = 0; j < pscl_pkg::HALF_W; j++) begin
            mask_v6_up[j] = (9'(j) + 9'(r_v6_len)) >= 9'd64;
            mask_v6_lo[j] = (9'(j) + 9'(r_v6_len)) >= 9'd128;
        end
    end

    // Mask the incoming address and classify the check
    always_comb begin
        if (i_is_ipv6) begin
            in_pfx_upper = i_addr_upper & mask_v6_up;
            in_pfx_lower = i_addr_lower & mask_v6_lo;
            pfx_bad      = r_v6_len > pscl_pkg::V6_MAX_LEN;
        end else begin
            in_pfx_upper = '0;
            in_pfx_lower = {32'd0, i_addr_lower[pscl_pkg::V4_W-1:0] & mask_v4};
            pfx_bad      = r_v4_len > pscl_pkg::V4_MAX_LEN;
        end
        untracked = !r_limit_en || !i_addr_known || pfx_bad;
        if (SW'(r_slots_used) > SW'(SLOTS)) begin
            len_in = CW'(SLOTS);
        end else begin
            len_in = CW'(r_slots_used);
        end
    end

    // Compare the slot read back last cycle
    always_comb begin
        hit_id  = r_rd_vld && r_rd_data.used && (r_rd_data.conn_id == r_conn_id);
        hit_src = r_rd_vld && r_rd_data.used && (r_rd_data.family == r_family) &&
                  (r_rd_data.pfx_upper == r_pfx_upper) &&
                  (r_rd_data.pfx_lower == r_pfx_lower);
        is_free = r_rd_vld && !r_rd_data.used;
        last    = r_rd_vld && ((CW'(r_rd_idx) + CW'(1)) == r_scan_len);
        count_nx     = r_count + CW'(hit_src);
        have_free_nx = r_have_free || is_free;
        free_nx      = r_have_free ? r_free_idx : r_rd_idx;
        if (SW'(count_nx) > SW'(127)) begin
            count_sat = 7'd127;
        end else begin
            count_sat = 7'(count_nx);
        end
    end

    // Sequence clearing, scanning and result generation
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_rd_vld       = 1'b0;
        n_count        = r_count;
        n_have_free    = r_have_free;
        n_free_idx     = r_free_idx;
        n_out_valid    = 1'b0;
        n_allowed      = r_allowed;
        n_status       = r_status;
        n_slot_index   = r_slot_index;
        n_source_count = r_source_count;
        mem_we         = 1'b0;
        mem_waddr      = r_addr[AW-1:0];
        mem_wdata      = '0;
        case (r_state)
            pscl_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == CW'(SLOTS - 1)) begin
                    n_state = pscl_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end
            pscl_pkg::S_IDLE: begin
                if (accept) begin
                    n_addr      = '0;
                    n_count     = '0;
                    n_have_free = 1'b0;
                    n_allowed      = 1'b1;
                    n_slot_index   = '0;
                    n_source_count = '0;
                    if (i_opcode == pscl_pkg::OP_RELEASE) begin
                        if (!r_limit_en || (len_in == '0)) begin
                            n_out_valid = 1'b1;
                            n_status    = pscl_pkg::STAT_NOT_FOUND;
                        end else begin
                            n_state = pscl_pkg::S_SCAN;
                        end
                    end else if (untracked) begin
                        n_out_valid = 1'b1;
                        n_status    = pscl_pkg::STAT_UNTRACKED;
                    end else if (len_in == '0) begin
                        n_out_valid = 1'b1;
                        n_allowed   = 1'b0;
                        n_status    = pscl_pkg::STAT_NO_SLOT;
                    end else begin
                        n_state = pscl_pkg::S_SCAN;
                    end
                end
            end
            pscl_pkg::S_SCAN: begin
                // issue the next read while slots remain
                if (r_addr < r_scan_len) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + CW'(1);
                end
                if (r_opcode == pscl_pkg::OP_RELEASE) begin
                    if (hit_id) begin
                        mem_we         = 1'b1;
                        mem_waddr      = r_rd_idx;
                        mem_wdata      = r_rd_data;
                        mem_wdata.used = 1'b0;
                        n_out_valid    = 1'b1;
                        n_allowed      = 1'b1;
                        n_status       = pscl_pkg::STAT_RELEASED;
                        n_slot_index   = pscl_pkg::IDX_OUT_W'(r_rd_idx);
                        n_source_count = '0;
                        n_rd_vld       = 1'b0;
                        n_state        = pscl_pkg::S_IDLE;
                    end else if (last) begin
                        n_out_valid    = 1'b1;
                        n_allowed      = 1'b1;
                        n_status       = pscl_pkg::STAT_NOT_FOUND;
                        n_slot_index   = '0;
                        n_source_count = '0;
                        n_rd_vld       = 1'b0;
                        n_state        = pscl_pkg::S_IDLE;
                    end
                end else begin
                    n_count     = count_nx;
                    n_have_free = have_free_nx;
                    n_free_idx  = free_nx;
                    if (last) begin
                        n_out_valid    = 1'b1;
                        n_source_count = count_sat;
                        n_rd_vld       = 1'b0;
                        n_state        = pscl_pkg::S_IDLE;
                        if (!have_free_nx) begin
                            n_allowed    = 1'b0;
                            n_status     = pscl_pkg::STAT_NO_SLOT;
                            n_slot_index = '0;
                        end else if (SW'(count_nx) >= SW'(r_src_limit)) begin
                            n_allowed    = 1'b0;
                            n_status     = pscl_pkg::STAT_OVER_LIMIT;
                            n_slot_index = '0;
                        end else begin
                            // record the connection in the lowest free slot
                            mem_we              = 1'b1;
                            mem_waddr           = free_nx;
                            mem_wdata.used      = 1'b1;
                            mem_wdata.conn_id   = r_conn_id;
                            mem_wdata.family    = r_family;
                            mem_wdata.pfx_upper = r_pfx_upper;
                            mem_wdata.pfx_lower = r_pfx_lower;
                            n_allowed           = 1'b1;
                            n_status            = pscl_pkg::STAT_RECORDED;
                            n_slot_index        = pscl_pkg::IDX_OUT_W'(free_nx);
                        end
                    end
                end
            end
            default: begin
                n_state = pscl_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pscl_pkg::S_CLEAR;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Advance scan accumulators and result payload
    always_ff @(posedge i_clk) begin
        r_count        <= n_count;
        r_have_free    <= n_have_free;
        r_free_idx     <= n_free_idx;
        r_allowed      <= n_allowed;
        r_status       <= n_status;
        r_slot_index   <= n_slot_index;
        r_source_count <= n_source_count;
        r_rd_idx       <= r_addr[AW-1:0];
    end

    // Capture the command beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode    <= i_opcode;
            r_conn_id   <= i_conn_id;
            r_family    <= i_is_ipv6;
            r_pfx_upper <= in_pfx_upper;
            r_pfx_lower <= in_pfx_lower;
            r_scan_len  <= len_in;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_slot_mem[r_addr[AW-1:0]];
    end

    assign o_result_valid = r_out_valid;
    assign o_allowed      = r_allowed;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot_index;
    assign o_source_count = r_source_count;

    // Assertions
    `ASSERT_PROP(a_clear_no_result, i_clk, i_rst_n,
        (r_state == pscl_pkg::S_CLEAR) |=> !o_result_valid)
    `ASSERT_PROP(a_read_in_range, i_clk, i_rst_n,
        r_rd_vld |-> (CW'(r_rd_idx) < r_scan_len))
    `ASSERT_PROP(a_count_bounded, i_clk, i_rst_n,
        (r_state == pscl_pkg::S_SCAN) |-> (r_count <= r_scan_len))
    `ASSERT_NEVER(a_no_write_idle, i_clk, i_rst_n,
        mem_we && (r_state == pscl_pkg::S_IDLE))
    `ASSERT_PROP(a_refusal_shape, i_clk, i_rst_n,
        (o_result_valid && !o_allowed) |->
            (((o_status == pscl_pkg::STAT_NO_SLOT) ||
              (o_status == pscl_pkg::STAT_OVER_LIMIT)) && (o_slot_index == '0)))

endmodule

// ===== tb/sv/connection_admission_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// connection_admission_monitor
// Watches the command, register and result channels of the limiter. Keeps a
// shadow slot table and register set, predicts the answer to every accepted
// command beat and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module connection_admission_monitor #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic                            i_opcode,
    input  logic [pscl_pkg::ID_W-1:0]       i_conn_id,
    input  logic                            i_addr_known,
    input  logic                            i_is_ipv6,
    input  logic [pscl_pkg::HALF_W-1:0]     i_addr_upper,
    input  logic [pscl_pkg::HALF_W-1:0]     i_addr_lower,
    input  logic                            i_cfg_we,
    input  logic [pscl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pscl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_result_valid,
    input  logic                            i_allowed,
    input  logic [2:0]                      i_status,
    input  logic [pscl_pkg::IDX_OUT_W-1:0]  i_slot_index,
    input  logic [pscl_pkg::CNT_OUT_W-1:0]  i_source_count,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    typedef struct packed {
        logic                           allowed;
        pscl_pkg::t_status              status;
        logic [pscl_pkg::IDX_OUT_W-1:0] slot_index;
        logic [pscl_pkg::CNT_OUT_W-1:0] source_count;
    } t_answer;

    // Shadow registers
    logic                          limit_en;
    logic [6:0]                    scan_cfg;
    logic [6:0]                    src_limit;
    logic [pscl_pkg::V4_LEN_W-1:0] v4_len;
    logic [pscl_pkg::V6_LEN_W-1:0] v6_len;

    // Shadow slot table
    logic                        slot_used [TABLE_SLOTS];
    logic [pscl_pkg::ID_W-1:0]   slot_id   [TABLE_SLOTS];
    logic                        slot_fam  [TABLE_SLOTS];
    logic [pscl_pkg::HALF_W-1:0] slot_up   [TABLE_SLOTS];
    logic [pscl_pkg::HALF_W-1:0] slot_lo   [TABLE_SLOTS];

    t_answer expected_answers[$];
    int      mismatch_total = 0;

    // Top b bits of a 64-bit word set
    function automatic logic [pscl_pkg::HALF_W-1:0] prefix_mask(input int b);
        if (b <= 0) return '0;
        if (b >= pscl_pkg::HALF_W) return '1;
        return ~64'd0 << (pscl_pkg::HALF_W - b);
    endfunction

    // Work out the answer to one command and update the shadow table
    function automatic t_answer predict_admission(
        input logic                        op,
        input logic [pscl_pkg::ID_W-1:0]   id,
        input logic                        known,
        input logic                        fam,
        input logic [pscl_pkg::HALF_W-1:0] up_in,
        input logic [pscl_pkg::HALF_W-1:0] lo_in
    );
        t_answer                     ans;
        logic [pscl_pkg::HALF_W-1:0] up;
        logic [pscl_pkg::HALF_W-1:0] lo;
        logic [pscl_pkg::HALF_W-1:0] mask;
        int                          span;
        int                          count;
        int                          free_at;
        ans.allowed      = 1'b1;
        ans.status       = pscl_pkg::STAT_NOT_FOUND;
        ans.slot_index   = '0;
        ans.source_count = '0;
        span    = (int'(scan_cfg) > TABLE_SLOTS) ? TABLE_SLOTS : int'(scan_cfg);
        count   = 0;
        free_at = -1;

        // Release: free the lowest used slot with this id
        if (op == pscl_pkg::OP_RELEASE) begin
            if (limit_en) begin
                for (int i = 0; i < span; i++) begin
                    if (slot_used[i] && slot_id[i] == id) begin
                        slot_used[i]   = 1'b0;
                        ans.status     = pscl_pkg::STAT_RELEASED;
                        ans.slot_index = pscl_pkg::IDX_OUT_W'(i);
                        return ans;
                    end
                end
            end
            return ans;
        end

        ans.status = pscl_pkg::STAT_UNTRACKED;
        if (!limit_en || !known) return ans;

        // Mask the address to the family prefix; an unusable prefix admits untracked
        if (fam == 1'b0) begin
            if (v4_len > pscl_pkg::V4_MAX_LEN) return ans;
            mask = prefix_mask(int'(v4_len));
            up   = '0;
            lo   = {32'd0, lo_in[pscl_pkg::V4_W-1:0] &
                           mask[pscl_pkg::HALF_W-1:pscl_pkg::HALF_W-pscl_pkg::V4_W]};
        end else begin
            if (v6_len > pscl_pkg::V6_MAX_LEN) return ans;
            up = up_in & prefix_mask(int'(v6_len));
            lo = lo_in & ((v6_len > 8'd64) ?
                          prefix_mask(int'(v6_len) - pscl_pkg::HALF_W) : '0);
        end

        // Count matching sources and find the lowest free slot
        for (int i = 0; i < span; i++) begin
            if (!slot_used[i]) begin
                if (free_at < 0) free_at = i;
            end else if (slot_fam[i] == fam && slot_up[i] == up && slot_lo[i] == lo) begin
                count++;
            end
        end
        ans.source_count = pscl_pkg::CNT_OUT_W'((count > 127) ? 127 : count);

        if (free_at < 0) begin
            ans.allowed = 1'b0;
            ans.status  = pscl_pkg::STAT_NO_SLOT;
            return ans;
        end
        if (count >= int'(src_limit)) begin
            ans.allowed = 1'b0;
            ans.status  = pscl_pkg::STAT_OVER_LIMIT;
            return ans;
        end

        slot_used[free_at] = 1'b1;
        slot_id[free_at]   = id;
        slot_fam[free_at]  = fam;
        slot_up[free_at]   = up;
        slot_lo[free_at]   = lo;
        ans.status     = pscl_pkg::STAT_RECORDED;
        ans.slot_index = pscl_pkg::IDX_OUT_W'(free_at);
        return ans;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (!i_rst_n) begin
            limit_en  = 1'b0;
            scan_cfg  = pscl_pkg::RST_SLOTS_USED;
            src_limit = pscl_pkg::RST_SRC_LIMIT;
            v4_len    = pscl_pkg::RST_V4_LEN;
            v6_len    = pscl_pkg::RST_V6_LEN;
            for (int i = 0; i < TABLE_SLOTS; i++) slot_used[i] = 1'b0;
            expected_answers.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pscl_pkg::CFG_LIMIT_EN:   limit_en  = i_cfg_wdata[0];
                    pscl_pkg::CFG_SLOTS_USED: scan_cfg  = i_cfg_wdata[6:0];
                    pscl_pkg::CFG_SRC_LIMIT:  src_limit = i_cfg_wdata[6:0];
                    pscl_pkg::CFG_V4_LEN:     v4_len    = i_cfg_wdata[pscl_pkg::V4_LEN_W-1:0];
                    pscl_pkg::CFG_V6_LEN:     v6_len    = i_cfg_wdata[pscl_pkg::V6_LEN_W-1:0];
                    default: ;
                endcase
            end

            // Retire the oldest prediction against the result beat
            if (i_result_valid) begin
                if (expected_answers.size() == 0) begin
                    $error("result beat with nothing pending: status %0d", i_status);
                    mismatch_total++;
                end else begin
                    want = expected_answers.pop_front();
                    compare_field("allowed", int'(want.allowed), int'(i_allowed));
                    compare_field("status", int'(want.status), int'(i_status));
                    compare_field("slot_index", int'(want.slot_index), int'(i_slot_index));
                    compare_field("source_count", int'(want.source_count),
                                  int'(i_source_count));
                end
            end

            // Predict the answer to an accepted command beat
            if (i_start && !i_busy) begin
                expected_answers.push_back(predict_admission(i_opcode, i_conn_id,
                    i_addr_known, i_is_ipv6, i_addr_upper, i_addr_lower));
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= expected_answers.size();
    end

endmodule

// ===== tb/sv/per_source_connection_limiter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_source_connection_limiter_tb
// Drives the limiter with a directed opening (limiting off, table full, over
// limit, unknown address, unusable prefixes, empty scan), then phases of random
// checks and releases over a small address pool, each under its own register
// setting and one of three idle patterns. The monitor scores every answer.
// ----------------------------------------------------------------------------
module per_source_connection_limiter_tb;

    localparam real CLK_PERIOD      = 12.0;
    localparam int  RESET_CYCLES    = 12;
    localparam int  PHASES          = 8;
    localparam int  ITEMS_PER_PHASE = 169;
    localparam int  POOL            = 8;
    localparam int  TAIL_CYCLES     = 80;
    localparam int  TIMEOUT_NS      = 8_000_000;

    localparam logic [pscl_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            start          = 1'b0;
    logic                            busy;
    logic                            i_opcode       = pscl_pkg::OP_CHECK;
    logic [pscl_pkg::ID_W-1:0]       i_conn_id      = '0;
    logic                            i_addr_known   = 1'b0;
    logic                            i_is_ipv6      = 1'b0;
    logic [pscl_pkg::HALF_W-1:0]     i_addr_upper   = '0;
    logic [pscl_pkg::HALF_W-1:0]     i_addr_lower   = '0;
    logic                            i_cfg_we       = 1'b0;
    logic [pscl_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [pscl_pkg::CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                            o_result_valid;
    logic                            o_allowed;
    logic [2:0]                      o_status;
    logic [pscl_pkg::IDX_OUT_W-1:0]  o_slot_index;
    logic [pscl_pkg::CNT_OUT_W-1:0]  o_source_count;

    int mismatches;
    int answers_outstanding;
    int idle_pct = 0;

    logic [pscl_pkg::HALF_W-1:0] pool_up [POOL];
    logic [pscl_pkg::HALF_W-1:0] pool_lo [POOL];
    logic [pscl_pkg::ID_W-1:0]   issued_ids[$];

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    per_source_connection_limiter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_conn_id      (i_conn_id),
        .i_addr_known   (i_addr_known),
        .i_is_ipv6      (i_is_ipv6),
        .i_addr_upper   (i_addr_upper),
        .i_addr_lower   (i_addr_lower),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_allowed      (o_allowed),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_source_count (o_source_count)
    );

    connection_admission_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_conn_id      (i_conn_id),
        .i_addr_known   (i_addr_known),
        .i_is_ipv6      (i_is_ipv6),
        .i_addr_upper   (i_addr_upper),
        .i_addr_lower   (i_addr_lower),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_result_valid (o_result_valid),
        .i_allowed      (o_allowed),
        .i_status       (o_status),
        .i_slot_index   (o_slot_index),
        .i_source_count (o_source_count),
        .o_mismatches   (mismatches),
        .o_outstanding  (answers_outstanding)
    );

    // Offer one command beat, hold it until taken, then idle at random
    task automatic issue(input logic                        op,
                         input logic [pscl_pkg::ID_W-1:0]   id,
                         input logic                        known,
                         input logic                        fam,
                         input logic [pscl_pkg::HALF_W-1:0] up,
                         input logic [pscl_pkg::HALF_W-1:0] lo);
        start        <= 1'b1;
        i_opcode     <= op;
        i_conn_id    <= id;
        i_addr_known <= known;
        i_is_ipv6    <= fam;
        i_addr_upper <= up;
        i_addr_lower <= lo;
        do @(posedge i_clk); while (busy);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every answer is in and the block is idle
    task automatic wait_until_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (answers_outstanding != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pscl_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [pscl_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [pscl_pkg::CFG_DATA_W-1:0] en,
                              input logic [pscl_pkg::CFG_DATA_W-1:0] slots,
                              input logic [pscl_pkg::CFG_DATA_W-1:0] lim,
                              input logic [pscl_pkg::CFG_DATA_W-1:0] v4,
                              input logic [pscl_pkg::CFG_DATA_W-1:0] v6);
        wait_until_quiet();
        write_reg(pscl_pkg::CFG_LIMIT_EN, en);
        write_reg(pscl_pkg::CFG_SLOTS_USED, slots);
        write_reg(pscl_pkg::CFG_SRC_LIMIT, lim);
        write_reg(pscl_pkg::CFG_V4_LEN, v4);
        write_reg(pscl_pkg::CFG_V6_LEN, v6);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic                        op;
        logic [pscl_pkg::ID_W-1:0]   id;
        logic                        known;
        logic                        fam;
        logic [pscl_pkg::HALF_W-1:0] up;
        logic [pscl_pkg::HALF_W-1:0] lo;
        int                          pick;

        for (int k = 0; k < POOL; k++) begin
            pool_up[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Limiting off after reset
        issue(pscl_pkg::OP_CHECK, 16'h1234, 1'b1, 1'b0, '0, 64'h0000_0000_C0A8_0101);
        issue(pscl_pkg::OP_RELEASE, 16'h0000, 1'b1, 1'b0, '0, '0);

        // Four slots, two per source: fill the table, hit the limit, free slots
        set_config(8'd1, 8'd4, 8'd2, 8'd32, 8'd128);
        issue(pscl_pkg::OP_CHECK, 16'h0001, 1'b1, 1'b0, '0, 64'h0000_0000_C0A8_0101);
        issue(pscl_pkg::OP_CHECK, 16'h0002, 1'b1, 1'b0, '0, 64'h0000_0000_C0A8_0101);
        issue(pscl_pkg::OP_CHECK, 16'h0003, 1'b1, 1'b0, '1, 64'hFFFF_FFFF_C0A8_0101);
        issue(pscl_pkg::OP_CHECK, 16'h0004, 1'b0, 1'b1, '1, '1);
        issue(pscl_pkg::OP_CHECK, 16'hFFFF, 1'b1, 1'b1, '1, '1);
        issue(pscl_pkg::OP_CHECK, 16'h0000, 1'b1, 1'b1, '0, '0);
        issue(pscl_pkg::OP_CHECK, 16'h0005, 1'b1, 1'b0, '0, 64'h0000_0000_0A00_0001);
        issue(pscl_pkg::OP_RELEASE, 16'h0002, 1'b1, 1'b0, '0, '0);
        issue(pscl_pkg::OP_RELEASE, 16'hBEEF, 1'b1, 1'b0, '0, '0);
        issue(pscl_pkg::OP_RELEASE, 16'hFFFF, 1'b1, 1'b1, '1, '1);

        // Zero slots scanned: every tracked check finds no slot
        set_config(8'd1, 8'd0, 8'd2, 8'd32, 8'd128);
        issue(pscl_pkg::OP_CHECK, 16'h0006, 1'b1, 1'b0, '0, 64'h0000_0000_0A00_0002);

        // Slot count above range, zero limit, prefixes too long
        set_config(8'd1, 8'd100, 8'd0, 8'd40, 8'd200);
        write_reg(CFG_SPARE_IDX, 8'hFF);
        i_cfg_we <= 1'b0;
        issue(pscl_pkg::OP_CHECK, 16'h0007, 1'b1, 1'b0, '0, 64'h0000_0000_0A00_0003);
        issue(pscl_pkg::OP_CHECK, 16'h0008, 1'b1, 1'b1, {$urandom, $urandom},
              {$urandom, $urandom});

        // Empty prefixes under a zero limit
        set_config(8'd1, 8'd64, 8'd0, 8'd0, 8'd0);
        issue(pscl_pkg::OP_CHECK, 16'h0009, 1'b1, 1'b0, '0, 64'h0000_0000_0A00_0004);
        issue(pscl_pkg::OP_CHECK, 16'h000A, 1'b1, 1'b1, '1, '0);

        // Prefix lengths on and around the half-word boundary
        set_config(8'd1, 8'd64, 8'd127, 8'd0, 8'd64);
        issue(pscl_pkg::OP_CHECK, 16'h000B, 1'b1, 1'b0, '0, 64'h0000_0000_FFFF_FFFF);
        issue(pscl_pkg::OP_CHECK, 16'h000C, 1'b1, 1'b1, 64'h2001_0DB8_0000_0001, '1);
        set_config(8'd1, 8'd64, 8'd127, 8'd16, 8'd65);
        issue(pscl_pkg::OP_CHECK, 16'h000D, 1'b1, 1'b1, 64'h2001_0DB8_0000_0001, '1);
        issue(pscl_pkg::OP_CHECK, 16'h000E, 1'b1, 1'b0, '0, 64'h0000_0000_0A00_FFFF);
        issue(pscl_pkg::OP_RELEASE, 16'h0001, 1'b1, 1'b0, '0, '0);
        issue(pscl_pkg::OP_RELEASE, 16'h0003, 1'b1, 1'b0, '0, '0);

        // Random phases with per-phase register settings, three idle patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_config(8'd1, 8'd64, 8'd64, 8'd32, 8'd128);
                1: set_config(8'd1, 8'd8, 8'd3, 8'd24, 8'd56);
                2: set_config(8'd1, 8'd1, 8'd1, 8'd0, 8'd0);
                3: set_config(8'd1, 8'($urandom_range(65, 127)), 8'd127, 8'd32, 8'd128);
                4: set_config(8'd1, 8'd16, 8'($urandom_range(0, 2)),
                              8'($urandom_range(0, 32)), 8'($urandom_range(0, 128)));
                5: set_config(8'd0, 8'd64, 8'd64, 8'd32, 8'd128);
                6: set_config(8'd1, 8'd32, 8'd4, 8'($urandom_range(33, 63)),
                              8'($urandom_range(0, 128)));
                default: set_config(8'd1, 8'($urandom_range(1, 64)), 8'($urandom_range(1, 8)),
                                    8'($urandom_range(0, 32)), 8'($urandom_range(129, 255)));
            endcase
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 57;
                default: idle_pct = 8;
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Pick the operation and id; releases mostly target issued ids
                op = ($urandom_range(99) < 60) ? pscl_pkg::OP_CHECK : pscl_pkg::OP_RELEASE;
                id = pscl_pkg::ID_W'($urandom);
                if (issued_ids.size() != 0) begin
                    if ((op == pscl_pkg::OP_RELEASE && $urandom_range(3) != 0) ||
                        (op == pscl_pkg::OP_CHECK && $urandom_range(4) == 0))
                        id = issued_ids[$urandom_range(issued_ids.size() - 1)];
                end
                known = ($urandom_range(9) != 0);
                fam   = 1'($urandom_range(1));

                // Mostly pool addresses with jitter in the low bits, some noise
                pick = $urandom_range(POOL - 1);
                if ($urandom_range(4) != 0) begin
                    up = pool_up[pick];
                    lo = pool_lo[pick];
                    if ($urandom_range(1) != 0)
                        lo ^= {$urandom, $urandom} & ((64'd1 << $urandom_range(16)) - 64'd1);
                    if ($urandom_range(3) == 0)
                        up ^= {$urandom, $urandom} & ((64'd1 << $urandom_range(16)) - 64'd1);
                end else begin
                    up = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                end
                if (fam == 1'b0 && $urandom_range(2) != 0) begin
                    up         = '0;
                    lo[63:32]  = '0;
                end

                if (op == pscl_pkg::OP_CHECK) begin
                    issued_ids.push_back(id);
                    if (issued_ids.size() > 64) void'(issued_ids.pop_front());
                end
                issue(op, id, known, fam, up, lo);

                // Now and then let the table settle with nothing in flight
                if ($urandom_range(99) == 0) wait_until_quiet();
            end
        end

        wait_until_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && answers_outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pscl_pkg.sv
hw/rtl/per_source_connection_limiter.sv
tb/sv/connection_admission_monitor.sv
tb/sv/per_source_connection_limiter_tb.sv
